// File: hw/rtl/dc_pkg.sv
// Shared types and constants for the divisor count block.
// Used by the top level, the shared divider and the port checker.
`default_nettype none
package dc_pkg;

  localparam int COUNT_WIDTH = 11;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_STRIP  = 6'b000010,
    S_CHECK  = 6'b000100,
    S_LAUNCH = 6'b001000,
    S_WAIT   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/dc_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all trial divisors.
// Depends on dc_pkg for the status struct.
`default_nettype none
module dc_divider #(
  parameter int NW = 31,
  parameter int DW = 17
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NW-1:0]     dividend,
  input  wire logic [DW-1:0]     divisor,
  output logic [NW-1:0]          quotient,
  output logic [DW-1:0]          remainder,
  output dc_pkg::div_stat_t      stat
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNTW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NW-2:0], fits};
      rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat      = '{busy: busy_r, done: done_r};

endmodule
`default_nettype wire

// File: hw/rtl/divisor_count_core.sv
// Divisor count of one integer by trial division (2, then odd d < SIEVE_LIMIT while d*d <= n).
// Per item, S_STRIP shifts out factors of 2, then for each odd trial d S_CHECK tests the bound,
// S_LAUNCH starts the shared divider (one quotient bit per cycle), S_WAIT takes its result
// and divides n by d again on a zero remainder; S_FINISH loads the result register. One item
// at a time; in_ready is high only when no item is in work. The result register frees in_ready.
// Reset (synchronous, rst_n low) returns to idle and empties the result register.
`default_nettype none
module divisor_count_core #(
  parameter int NUMBER_WIDTH = 31,
  parameter int SIEVE_LIMIT  = 65536
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [NUMBER_WIDTH-1:0]         in_number,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [dc_pkg::COUNT_WIDTH-1:0]       out_divisor_count
);

  localparam int NW   = NUMBER_WIDTH;
  localparam int DW   = $clog2(SIEVE_LIMIT + 2);
  localparam int SQW  = 2 * DW;
  localparam int CMPW = (SQW > NW) ? SQW : NW;
  localparam int EW   = $clog2(NUMBER_WIDTH + 2);
  localparam int CW   = dc_pkg::COUNT_WIDTH;
  localparam logic [DW-1:0] LIMIT_D = DW'(SIEVE_LIMIT);

  dc_pkg::state_t    state_r, state_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [DW-1:0]     d_r, d_nxt;
  logic [SQW-1:0]    sq_r, sq_nxt;
  logic [EW-1:0]     e_r, e_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CW-1:0]     out_count_r, out_count_nxt;

  logic [CW+EW-1:0]  prod;
  logic [CW-1:0]     count_mul;
  logic              go;
  logic              div_start;
  logic [NW-1:0]     div_quo;
  logic [DW-1:0]     div_rem;
  dc_pkg::div_stat_t div_stat;

  assign prod      = count_r * (e_r + EW'(1));
  assign count_mul = prod[CW-1:0];
  assign go        = (d_r < LIMIT_D) && (CMPW'(sq_r) <= CMPW'(n_r));
  assign div_start = (state_r == dc_pkg::S_LAUNCH);

  dc_divider #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (d_r),
    .quotient (div_quo),
    .remainder(div_rem),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    e_nxt         = e_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      dc_pkg::S_IDLE: begin
        if (in_valid) begin
          n_nxt     = in_number;
          e_nxt     = '0;
          count_nxt = CW'(1);
          if (in_number == '0) begin
            count_nxt = '0;
            state_nxt = dc_pkg::S_FINISH;
          end else begin
            state_nxt = dc_pkg::S_STRIP;
          end
        end
      end
      dc_pkg::S_STRIP: begin
        if (!n_r[0]) begin
          n_nxt = n_r >> 1;
          e_nxt = e_r + EW'(1);
        end else begin
          count_nxt = count_mul;
          e_nxt     = '0;
          d_nxt     = DW'(3);
          sq_nxt    = SQW'(9);
          state_nxt = dc_pkg::S_CHECK;
        end
      end
      dc_pkg::S_CHECK: begin
        if (go) begin
          state_nxt = dc_pkg::S_LAUNCH;
        end else begin
          if (n_r > NW'(1)) begin
            count_nxt = {count_r[CW-2:0], 1'b0};
          end
          state_nxt = dc_pkg::S_FINISH;
        end
      end
      dc_pkg::S_LAUNCH: begin
        state_nxt = dc_pkg::S_WAIT;
      end
      dc_pkg::S_WAIT: begin
        if (div_stat.done) begin
          if (div_rem == '0) begin
            n_nxt     = div_quo;
            e_nxt     = e_r + EW'(1);
            state_nxt = dc_pkg::S_LAUNCH;
          end else begin
            count_nxt = count_mul;
            e_nxt     = '0;
            d_nxt     = d_r + DW'(2);
            sq_nxt    = sq_r + SQW'({d_r, 2'b00}) + SQW'(4);
            state_nxt = dc_pkg::S_CHECK;
          end
        end
      end
      dc_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          state_nxt     = dc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    e_r         <= e_nxt;
    count_r     <= count_nxt;
    out_count_r <= out_count_nxt;
  end

  assign in_ready          = (state_r == dc_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_divisor_count = out_count_r;

endmodule
`default_nettype wire

// File: hw/rtl/dc_checker.sv
// Port-level checks for divisor_count_core, attached by the bind below.
// Depends on dc_pkg for the result width.
`default_nettype none
module dc_checker #(
  parameter int NUMBER_WIDTH = 31
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [NUMBER_WIDTH-1:0]       in_number,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [dc_pkg::COUNT_WIDTH-1:0] out_divisor_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_divisor_count))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an item was taken");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result item appeared without an item in work");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not return to idle");

  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_number == '0) |=> !in_ready)
    else $error("zero item not held in work");

endmodule

bind divisor_count_core dc_checker #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_dc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_number        (in_number),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_divisor_count(out_divisor_count)
);
`default_nettype wire

// File: sim/divisor_count_checker.sv
// Port checker for divisor_count_core: watches both channels, predicts each divisor count
// by trial division and compares it with the item that comes out. Uses dc_pkg.
`timescale 1ns / 100ps
module divisor_count_checker #(
  parameter int NUMBER_WIDTH = 31,
  parameter int SIEVE_LIMIT  = 65536
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [NUMBER_WIDTH-1:0]        in_number,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic [dc_pkg::COUNT_WIDTH-1:0] out_divisor_count,
  output int                                  mismatch_count,
  output int                                  pending_count,
  output int                                  checked_count
);

  logic [dc_pkg::COUNT_WIDTH-1:0] expected_counts [$];
  logic [dc_pkg::COUNT_WIDTH-1:0] wanted_count;
  int                             mismatches = 0;
  int                             checked    = 0;

  function automatic logic [dc_pkg::COUNT_WIDTH-1:0] divisor_count_of(
    input logic [NUMBER_WIDTH-1:0] number
  );
    longint unsigned rest;
    longint unsigned trial;
    int unsigned     total;
    int unsigned     expo;
    rest = number;
    if (rest == 0) begin
      return '0;
    end
    total = 1;
    expo  = 0;
    while (rest[0] == 1'b0) begin
      rest = rest >> 1;
      expo++;
    end
    total = total * (expo + 1);
    for (trial = 3; trial < SIEVE_LIMIT && trial * trial <= rest; trial += 2) begin
      expo = 0;
      while (rest % trial == 0) begin
        rest = rest / trial;
        expo++;
      end
      total = total * (expo + 1);
    end
    if (rest > 1) begin
      total = total * 2;
    end
    return total[dc_pkg::COUNT_WIDTH-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_counts.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_counts.insert(expected_counts.size(), divisor_count_of(in_number));
      end
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          $error("divisor_count: unexpected item, expected none, actual %0d",
                 out_divisor_count);
          mismatches++;
        end else begin
          wanted_count = expected_counts.pop_front();
          checked++;
          if (out_divisor_count !== wanted_count) begin
            $error("divisor_count: expected %0d, actual %0d", wanted_count,
                   out_divisor_count);
            mismatches++;
          end
        end
      end
    end
    mismatch_count <= mismatches;
    checked_count  <= checked;
    pending_count  <= expected_counts.size();
  end

endmodule

// File: sim/tb_divisor_count_core.sv
// Testbench top for divisor_count_core: drives numbers through the valid/ready channels
// under varying idle rates and a long output stall; divisor_count_checker does the checking.
`timescale 1ns / 100ps
module tb_divisor_count_core;

  localparam int NUMBER_WIDTH = 31;
  localparam int SIEVE_LIMIT  = 65536;
  localparam int LONG_STALL   = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [NUMBER_WIDTH-1:0] DIRECTED_NUMBERS [18] = '{
    31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd9, 31'd63001, 31'd720720, 31'd65535,
    31'd65536, 31'd999983, 31'd1162261467, 31'd1073741824, 31'd2095133040,
    31'd1073741823, 31'd2147418112, 31'd2147483646, 31'd2147483647
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [NUMBER_WIDTH-1:0]        in_number = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [dc_pkg::COUNT_WIDTH-1:0] out_divisor_count;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int send_idle_pct = 33;
  int recv_idle_pct = 48;
  int hold_requests = 0;
  int sent_count    = 0;

  divisor_count_core #(
    .NUMBER_WIDTH(NUMBER_WIDTH),
    .SIEVE_LIMIT (SIEVE_LIMIT)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_divisor_count(out_divisor_count)
  );

  divisor_count_checker #(
    .NUMBER_WIDTH(NUMBER_WIDTH),
    .SIEVE_LIMIT (SIEVE_LIMIT)
  ) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_divisor_count(out_divisor_count),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count),
    .checked_count    (checked_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_number(input logic [NUMBER_WIDTH-1:0] number);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= number;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // mostly cheap numbers; smooth shifted values reach the top bits without long trials
  function automatic logic [NUMBER_WIDTH-1:0] random_number();
    int unsigned             pick;
    int unsigned             odd_part;
    int unsigned             shift;
    logic [NUMBER_WIDTH-1:0] number;
    pick = $urandom_range(99);
    if (pick < 60) begin
      number = NUMBER_WIDTH'($urandom_range(16383, 1));
    end else if (pick < 85) begin
      odd_part = $urandom_range(4095, 1);
      shift    = $urandom_range(NUMBER_WIDTH - 1, 8);
      number   = NUMBER_WIDTH'(odd_part << shift);
      if (number == 0) begin
        number = NUMBER_WIDTH'(1) << shift;
      end
    end else if (pick < 95) begin
      number = NUMBER_WIDTH'($urandom_range(1 << 20, 16384));
    end else begin
      number = NUMBER_WIDTH'($urandom_range(3, 0));
    end
    return number;
  endfunction

  initial begin : receiver
    int holds_seen;
    int stall_left;
    holds_seen = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #250_000_000;
    $display("Timeout with %0d items still pending", pending_count);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_NUMBERS[i]) begin
      send_number(DIRECTED_NUMBERS[i]);
    end
    repeat (30) send_number(random_number());

    send_idle_pct = 48;
    recv_idle_pct = 33;
    repeat (35) send_number(random_number());

    // hold the output off while items keep coming so the input stalls
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (35) send_number(random_number());
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (directed extremes, zero, primes, smooth and random numbers)",
             sent_count);
    $display("Checked %0d results across three idle mixes and a %0d-cycle output stall",
             checked_count, LONG_STALL);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
